@@ sv/csd_pkg.sv @@
// Shared types, codes and constants for the capsule stream decoder.
package csd_pkg;

  localparam int unsigned MAX_REASON_BYTES = 1024;
  localparam logic [61:0] CLOSE_LEN_MIN = 62'd4;
  localparam logic [61:0] CLOSE_LEN_MAX = 62'(4 + MAX_REASON_BYTES);

  localparam logic [61:0] CLOSE_TYPE_RESET = 62'd10307;
  localparam logic [61:0] DRAIN_TYPE_RESET = 62'd30894;

  // Result queue depth; must be a power of two and at least 4.
  localparam int unsigned OUT_DEPTH = 4;
  localparam int unsigned OUT_PTR_W = $clog2(OUT_DEPTH);
  localparam int unsigned OUT_CNT_W = $clog2(OUT_DEPTH + 1);

  // Commands
  localparam logic CMD_FEED   = 1'b0;
  localparam logic CMD_REINIT = 1'b1;

  // Configuration register indexes
  localparam logic CFG_CLOSE_TYPE = 1'b0;
  localparam logic CFG_DRAIN_TYPE = 1'b1;

  // Result events
  localparam logic [1:0] EV_REASON    = 2'd0;
  localparam logic [1:0] EV_COMPLETE  = 2'd1;
  localparam logic [1:0] EV_MALFORMED = 2'd2;

  // Capsule kinds
  localparam logic [1:0] KIND_UNKNOWN = 2'd0;
  localparam logic [1:0] KIND_CLOSE   = 2'd1;
  localparam logic [1:0] KIND_DRAIN   = 2'd2;

  typedef enum logic [2:0] {
    PH_HEADER  = 3'b001,
    PH_PAYLOAD = 3'b010,
    PH_POISON  = 3'b100
  } phase_t;

  typedef struct packed {
    logic       command;
    logic [7:0] data_byte;
  } csd_in_t;

  typedef struct packed {
    logic [1:0]  event_res;
    logic        byte_consumed;
    logic [1:0]  capsule_kind;
    logic [61:0] capsule_type_out;
    logic [61:0] payload_length;
    logic [4:0]  header_length;
    logic [31:0] err_code;
    logic [10:0] reason_length;
    logic [7:0]  reason_byte;
    logic        last;
  } csd_out_t;

  typedef struct packed {
    logic push_a;
    logic push_b;
    logic poisoned;
  } csd_dec_status_t;

endpackage

@@ sv/csd_decoder.sv @@
// Per-byte capsule parser: header varints, close payload, skip and poison logic.
module csd_decoder #(
  parameter int unsigned MAX_REASON_BYTES = csd_pkg::MAX_REASON_BYTES
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     step,
  input  csd_pkg::csd_in_t         in_item,
  input  logic [61:0]              close_type,
  input  logic [61:0]              drain_type,
  output csd_pkg::csd_out_t        res_a,
  output csd_pkg::csd_out_t        res_b,
  output csd_pkg::csd_dec_status_t status
);

  localparam logic [61:0] CLOSE_LEN_MAX = 62'(4 + MAX_REASON_BYTES);

  csd_pkg::phase_t phase_r, phase_nxt;
  logic        sel_r, sel_nxt;
  logic [2:0]  left_r, left_nxt;
  logic [61:0] acc_r, acc_nxt;
  logic [61:0] type_r, type_nxt;
  logic [61:0] len_r, len_nxt;
  logic [61:0] rem_r, rem_nxt;
  logic [4:0]  hlen_r, hlen_nxt;
  logic [1:0]  kind_r, kind_nxt;
  logic [2:0]  seen_r, seen_nxt;
  logic [31:0] code_r, code_nxt;
  logic [10:0] rcnt_r, rcnt_nxt;

  // Extra bytes that follow the first byte of a varint: 0, 1, 3 or 7.
  function automatic logic [2:0] varint_extra(input logic [1:0] prefix);
    logic [2:0] n;
    begin
      n = 3'd0;
      unique case (prefix)
        2'd0:    n = 3'd0;
        2'd1:    n = 3'd1;
        2'd2:    n = 3'd3;
        default: n = 3'd7;
      endcase
      return n;
    end
  endfunction

  logic [7:0]  b;
  logic [61:0] acc_v;
  logic [2:0]  left_v;
  logic        is_close, is_drain, bad, last_byte;
  logic [31:0] code_v;
  logic [10:0] rcnt_v;
  logic        emit_reason;
  csd_pkg::csd_out_t base, r_reason, r_done;

  always_comb begin
    b        = in_item.data_byte;
    is_close = (type_r == close_type);
    is_drain = (type_r == drain_type);
    acc_v    = '0;
    left_v   = '0;
    bad      = 1'b0;
    last_byte   = (rem_r == 62'd1);
    code_v      = code_r;
    rcnt_v      = rcnt_r;
    emit_reason = 1'b0;

    phase_nxt = phase_r;
    sel_nxt   = sel_r;
    left_nxt  = left_r;
    acc_nxt   = acc_r;
    type_nxt  = type_r;
    len_nxt   = len_r;
    rem_nxt   = rem_r;
    hlen_nxt  = hlen_r;
    kind_nxt  = kind_r;
    seen_nxt  = seen_r;
    code_nxt  = code_r;
    rcnt_nxt  = rcnt_r;

    base                  = '0;
    base.byte_consumed    = 1'b1;
    base.capsule_type_out = type_r;
    base.payload_length   = len_r;
    base.header_length    = hlen_r;
    res_a       = base;
    res_b       = base;
    r_reason    = base;
    r_done      = base;
    status      = '0;
    status.poisoned = (phase_r == csd_pkg::PH_POISON);

    if (step) begin
      if (in_item.command == csd_pkg::CMD_REINIT) begin
        phase_nxt = csd_pkg::PH_HEADER;
        sel_nxt = 1'b0; left_nxt = '0; acc_nxt = '0; type_nxt = '0;
        len_nxt = '0; rem_nxt = '0; hlen_nxt = '0; kind_nxt = '0;
        seen_nxt = '0; code_nxt = '0; rcnt_nxt = '0;
      end else begin
        unique case (phase_r)
          csd_pkg::PH_POISON: begin
            res_a           = '0;
            res_a.event_res = csd_pkg::EV_MALFORMED;
            res_a.last      = 1'b1;
            status.push_a   = 1'b1;
          end
          csd_pkg::PH_HEADER: begin
            hlen_nxt = (hlen_r != 5'd31) ? 5'(hlen_r + 5'd1) : hlen_r;
            if (left_r == 3'd0) begin
              acc_v  = {56'd0, b[5:0]};
              left_v = varint_extra(b[7:6]);
            end else begin
              acc_v  = {acc_r[53:0], b};
              left_v = 3'(left_r - 3'd1);
            end
            acc_nxt  = acc_v;
            left_nxt = left_v;
            if (left_v == 3'd0) begin
              acc_nxt = '0;
              if (!sel_r) begin
                type_nxt = acc_v;
                sel_nxt  = 1'b1;
              end else begin
                // Length varint done: classify and check the capsule shape.
                len_nxt  = acc_v;
                rem_nxt  = acc_v;
                sel_nxt  = 1'b0;
                seen_nxt = '0;
                code_nxt = '0;
                rcnt_nxt = '0;
                if (is_close) begin
                  bad = (acc_v < csd_pkg::CLOSE_LEN_MIN) || (acc_v > CLOSE_LEN_MAX);
                end else if (is_drain) begin
                  bad = (acc_v != 62'd0);
                end
                res_a.payload_length = acc_v;
                res_a.header_length  = hlen_nxt;
                res_a.last           = 1'b1;
                if (bad) begin
                  res_a.event_res = csd_pkg::EV_MALFORMED;
                  status.push_a   = 1'b1;
                  phase_nxt       = csd_pkg::PH_POISON;
                end else begin
                  kind_nxt = is_close ? csd_pkg::KIND_CLOSE :
                             is_drain ? csd_pkg::KIND_DRAIN : csd_pkg::KIND_UNKNOWN;
                  if (acc_v == 62'd0) begin
                    res_a.event_res    = csd_pkg::EV_COMPLETE;
                    res_a.capsule_kind = kind_nxt;
                    status.push_a      = 1'b1;
                    phase_nxt = csd_pkg::PH_HEADER;
                    type_nxt = '0; len_nxt = '0; hlen_nxt = '0; kind_nxt = '0;
                  end else begin
                    phase_nxt = csd_pkg::PH_PAYLOAD;
                  end
                end
              end
            end
          end
          csd_pkg::PH_PAYLOAD: begin
            if (kind_r == csd_pkg::KIND_CLOSE) begin
              if (seen_r < 3'd4) begin
                code_v   = {code_r[23:0], b};
                seen_nxt = 3'(seen_r + 3'd1);
              end else begin
                rcnt_v      = 11'(rcnt_r + 11'd1);
                emit_reason = 1'b1;
              end
            end
            code_nxt = code_v;
            rcnt_nxt = rcnt_v;
            rem_nxt  = 62'(rem_r - 62'd1);

            r_reason.event_res     = csd_pkg::EV_REASON;
            r_reason.capsule_kind  = csd_pkg::KIND_CLOSE;
            r_reason.err_code      = code_v;
            r_reason.reason_length = rcnt_v;
            r_reason.reason_byte   = b;
            r_reason.last          = !last_byte;

            r_done.event_res    = csd_pkg::EV_COMPLETE;
            r_done.capsule_kind = kind_r;
            if (kind_r == csd_pkg::KIND_CLOSE) begin
              r_done.err_code      = code_v;
              r_done.reason_length = rcnt_v;
            end
            r_done.last = 1'b1;

            if (emit_reason) begin
              res_a         = r_reason;
              res_b         = r_done;
              status.push_a = 1'b1;
              status.push_b = last_byte;
            end else begin
              res_a         = r_done;
              status.push_a = last_byte;
            end

            if (last_byte) begin
              phase_nxt = csd_pkg::PH_HEADER;
              sel_nxt = 1'b0; left_nxt = '0; acc_nxt = '0; type_nxt = '0;
              len_nxt = '0; rem_nxt = '0; hlen_nxt = '0; kind_nxt = '0;
              seen_nxt = '0; code_nxt = '0; rcnt_nxt = '0;
            end
          end
          default: begin
            phase_nxt = csd_pkg::PH_HEADER;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= csd_pkg::PH_HEADER;
      sel_r   <= 1'b0;
      left_r  <= '0;
      acc_r   <= '0;
      type_r  <= '0;
      len_r   <= '0;
      rem_r   <= '0;
      hlen_r  <= '0;
      kind_r  <= '0;
      seen_r  <= '0;
      code_r  <= '0;
      rcnt_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      sel_r   <= sel_nxt;
      left_r  <= left_nxt;
      acc_r   <= acc_nxt;
      type_r  <= type_nxt;
      len_r   <= len_nxt;
      rem_r   <= rem_nxt;
      hlen_r  <= hlen_nxt;
      kind_r  <= kind_nxt;
      seen_r  <= seen_nxt;
      code_r  <= code_nxt;
      rcnt_r  <= rcnt_nxt;
    end
  end

endmodule

@@ sv/csd_result_fifo.sv @@
// Small result queue taking up to two results per cycle and giving one.
module csd_result_fifo (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              push_a,
  input  logic                              push_b,
  input  csd_pkg::csd_out_t                 data_a,
  input  csd_pkg::csd_out_t                 data_b,
  input  logic                              pop,
  output csd_pkg::csd_out_t                 head,
  output logic                              not_empty,
  output logic [csd_pkg::OUT_CNT_W-1:0]     level
);

  csd_pkg::csd_out_t mem_r [csd_pkg::OUT_DEPTH];
  logic [csd_pkg::OUT_PTR_W-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [csd_pkg::OUT_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [csd_pkg::OUT_PTR_W-1:0] wr_b;

  assign wr_b      = csd_pkg::OUT_PTR_W'(wr_r + 1'b1);
  assign head      = mem_r[rd_r];
  assign not_empty = (cnt_r != '0);
  assign level     = cnt_r;

  always_comb begin
    wr_nxt  = csd_pkg::OUT_PTR_W'(wr_r + csd_pkg::OUT_PTR_W'(push_a)
                                       + csd_pkg::OUT_PTR_W'(push_b));
    rd_nxt  = csd_pkg::OUT_PTR_W'(rd_r + csd_pkg::OUT_PTR_W'(pop));
    cnt_nxt = csd_pkg::OUT_CNT_W'(cnt_r + csd_pkg::OUT_CNT_W'(push_a)
                                        + csd_pkg::OUT_CNT_W'(push_b)
                                        - csd_pkg::OUT_CNT_W'(pop));
  end

  always_ff @(posedge clk) begin
    if (push_a) begin
      mem_r[wr_r] <= data_a;
    end
    if (push_b) begin
      mem_r[wr_b] <= data_b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

@@ sv/capsule_stream_decoder_core.sv @@
// Capsule stream decoder top level: config registers, parser and result queue.
// A result is visible on out_valid in the cycle after its byte is taken.
// Throughput: one byte per cycle; a byte yields zero, one or two results and the
//   four-entry result queue stalls input only when it holds three or more.
// Reset (synchronous, rst_n low): parser back to header state, queue emptied,
//   type registers back to their defaults.
module capsule_stream_decoder_core #(
  parameter int unsigned MAX_REASON_BYTES = csd_pkg::MAX_REASON_BYTES
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  csd_pkg::csd_in_t   in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output csd_pkg::csd_out_t  out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [61:0]        cfg_data
);

  logic [61:0] close_type_r, drain_type_r;
  logic        step, pop;
  csd_pkg::csd_out_t res_a, res_b;
  csd_pkg::csd_dec_status_t dec_status;
  logic [csd_pkg::OUT_CNT_W-1:0] fifo_level;

  assign cfg_ready = 1'b1;
  assign in_stall  = (fifo_level > csd_pkg::OUT_CNT_W'(csd_pkg::OUT_DEPTH - 2));
  assign step      = in_valid && !in_stall;
  assign pop       = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      close_type_r <= csd_pkg::CLOSE_TYPE_RESET;
      drain_type_r <= csd_pkg::DRAIN_TYPE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        csd_pkg::CFG_CLOSE_TYPE: close_type_r <= cfg_data;
        csd_pkg::CFG_DRAIN_TYPE: drain_type_r <= cfg_data;
        default: ;
      endcase
    end
  end

  csd_decoder #(
    .MAX_REASON_BYTES (MAX_REASON_BYTES)
  ) u_decoder (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .in_item    (in_data),
    .close_type (close_type_r),
    .drain_type (drain_type_r),
    .res_a      (res_a),
    .res_b      (res_b),
    .status     (dec_status)
  );

  csd_result_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_a    (dec_status.push_a),
    .push_b    (dec_status.push_b),
    .data_a    (res_a),
    .data_b    (res_b),
    .pop       (pop),
    .head      (out_data),
    .not_empty (out_valid),
    .level     (fifo_level)
  );

  // Queue never overfills.
  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_level <= csd_pkg::OUT_CNT_W'(csd_pkg::OUT_DEPTH))
    else $error("result queue overflow");

  // A second result only ever follows a first in the same request.
  a_push_order: assert property (@(posedge clk) disable iff (!rst_n)
    dec_status.push_b |-> dec_status.push_a)
    else $error("second result without first");

  // Reinitialize always clears the poisoned state.
  a_reinit_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (step && in_data.command == csd_pkg::CMD_REINIT) |=> !dec_status.poisoned)
    else $error("poison survived reinitialize");

  // A reinitialize request produces no result.
  a_reinit_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (step && in_data.command == csd_pkg::CMD_REINIT) |-> !dec_status.push_a)
    else $error("reinitialize produced a result");

endmodule
